// File: design/resp_request_frame_parser_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the request frame parser
// Shared concurrent assertion forms, all sampled on the rising clock edge
// and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef RESP_REQUEST_FRAME_PARSER_UNIT_MACROS_SVH
`define RESP_REQUEST_FRAME_PARSER_UNIT_MACROS_SVH

// Condition holds at every edge out of reset.
`define RRFP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RRFP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RRFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rrfp_pkg.sv
// ---------------------------------------------------------------------------
// Request frame parser package
// Field widths, character codes, result and error codes, register indexes.
// ---------------------------------------------------------------------------
package rrfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int ERR_W       = 3;
  localparam int ARGS_W      = 21;
  localparam int NUM_W       = 30;
  localparam int CFG_DATA_W  = 30;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_ARGS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARG_LENGTH = 1'd1;

  localparam logic [ARGS_W-1:0] MAX_FRAME_ARGS_RST = 21'd1048576;
  localparam logic [NUM_W-1:0]  MAX_ARG_LENGTH_RST = 30'd536870912;
  localparam logic [NUM_W-1:0]  NUM_MAX            = 30'h3FFF_FFFF;

  // Characters
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRAME_END = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_BAD_COUNT  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_DOLLAR  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_LENGTH = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_TRAILER = 3'd3;
  localparam logic [ERR_W-1:0] ERR_LONE_CR    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] arg_byte;
    logic              arg_first;
    logic              frame_inline;
    logic [ERR_W-1:0]  error_code;
    logic              last;
  } result_t;

endpackage

// File: design/rrfp_if.sv
// ---------------------------------------------------------------------------
// Request frame parser channels
// Valid/ready channels for raw request bytes and for parse results.
// ---------------------------------------------------------------------------
interface rrfp_in_if;
  import rrfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rrfp_out_if;
  import rrfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] arg_byte;
  logic              arg_first;
  logic              frame_inline;
  logic [ERR_W-1:0]  error_code;
  logic              last;

  modport source (output valid, output result_kind, output arg_byte, output arg_first,
                  output frame_inline, output error_code, output last, input ready);
  modport sink   (input valid, input result_kind, input arg_byte, input arg_first,
                  input frame_inline, input error_code, input last, output ready);
endinterface

// File: design/resp_request_frame_parser_unit.sv
// ---------------------------------------------------------------------------
// Request frame parser
// Byte-serial parser for multibulk and inline request frames.
// ---------------------------------------------------------------------------
// Takes one request byte per cycle and emits zero, one or two results for it
// (data byte, argument end, frame end, error) into a
// four-entry result queue. With the result side taking a result every cycle
// the block sustains one byte per cycle; a byte that yields two results
// needs two transfers on the output, and the input stalls while the queue has
// fewer than two free entries. The parse state is a single register stage
// updated by one pass of logic per byte: the count and length
// accumulation is a multiply by ten and add. Configuration writes take
// effect at the next edge and are meant to happen while the block is idle.
`include "resp_request_frame_parser_unit_macros.svh"

module resp_request_frame_parser_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rrfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rrfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  rrfp_in_if.sink                         in_ch,
  rrfp_out_if.source                      out_ch
);
  import rrfp_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_COUNT    = 4'd1;
  localparam logic [3:0] PH_COUNT_LF = 4'd2;
  localparam logic [3:0] PH_DOLLAR   = 4'd3;
  localparam logic [3:0] PH_LEN      = 4'd4;
  localparam logic [3:0] PH_LEN_LF   = 4'd5;
  localparam logic [3:0] PH_DATA     = 4'd6;
  localparam logic [3:0] PH_DATA_CR  = 4'd7;
  localparam logic [3:0] PH_DATA_LF  = 4'd8;
  localparam logic [3:0] PH_INLINE   = 4'd9;

  localparam logic [2:0] FIFO_DEPTH = 3'd4;
  localparam logic [2:0] FIFO_ROOM  = 3'd2;

  // Configuration
  logic [ARGS_W-1:0] max_frame_args;
  logic [NUM_W-1:0]  max_arg_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_args <= MAX_FRAME_ARGS_RST;
      max_arg_length <= MAX_ARG_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_FRAME_ARGS: max_frame_args <= cfg_data[ARGS_W-1:0];
        REG_MAX_ARG_LENGTH: max_arg_length <= cfg_data[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Parse state
  logic [3:0]        phase, phase_next;
  logic [ARGS_W-1:0] args_left, args_left_next;
  logic [NUM_W-1:0]  number, number_next;
  logic              number_overflow, number_overflow_next;
  logic              digit_seen, digit_seen_next;
  logic              held_cr, held_cr_next;
  logic              in_token, in_token_next;
  logic              is_inline, is_inline_next;

  // Result queue
  result_t    fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       in_fire, out_fire;
  result_t    res [2];
  logic [1:0] n_res;

  assign in_ch.ready = (count <= FIFO_ROOM);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  function automatic result_t mk(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                                 input logic first, input logic inl,
                                 input logic [ERR_W-1:0] code);
    result_t r;
    r.result_kind  = kind;
    r.arg_byte     = b;
    r.arg_first    = first;
    r.frame_inline = inl;
    r.error_code   = code;
    r.last         = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [BYTE_W-1:0] b;
    logic              digit;
    logic [NUM_W+3:0]  acc;
    logic              inl;
    logic              hc;
    logic              tk;
    logic              fail;
    logic [ERR_W-1:0]  fail_code;
    logic              clear;

    b         = in_ch.in_byte;
    digit     = (b >= CH_ZERO) && (b <= CH_NINE);
    acc       = {4'd0, number} * (NUM_W+4)'(10) + {26'd0, b - CH_ZERO};
    inl       = (phase == PH_IDLE) ? (b != CH_STAR) : is_inline;
    hc        = (phase == PH_IDLE) ? 1'b0 : held_cr;
    tk        = (phase == PH_IDLE) ? 1'b0 : in_token;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    clear     = 1'b0;

    phase_next           = phase;
    args_left_next       = args_left;
    number_next          = number;
    number_overflow_next = number_overflow;
    digit_seen_next      = digit_seen;
    held_cr_next         = held_cr;
    in_token_next        = in_token;
    is_inline_next       = is_inline;
    res[0]               = '0;
    res[1]               = '0;
    n_res                = 2'd0;

    unique case (phase)
      PH_COUNT, PH_LEN: begin
        if (digit) begin
          digit_seen_next = 1'b1;
          if (acc > {4'd0, NUM_MAX}) begin
            number_overflow_next = 1'b1;
            number_next          = NUM_MAX;
          end else begin
            number_next = acc[NUM_W-1:0];
          end
        end else if (b == CH_CR && digit_seen) begin
          phase_next = (phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else begin
          fail      = 1'b1;
          fail_code = (phase == PH_COUNT) ? ERR_BAD_COUNT : ERR_BAD_LENGTH;
        end
      end
      PH_COUNT_LF: begin
        if (b != CH_LF) begin
          fail      = 1'b1;
          fail_code = ERR_LONE_CR;
        end else if (number_overflow || number > {9'd0, max_frame_args}) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_COUNT;
        end else if (number == '0) begin
          res[0] = mk(KIND_FRAME_END, '0, 1'b0, inl, ERR_NONE);
          n_res  = 2'd1;
          clear  = 1'b1;
        end else begin
          args_left_next = number[ARGS_W-1:0];
          phase_next     = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) begin
          number_next          = '0;
          number_overflow_next = 1'b0;
          digit_seen_next      = 1'b0;
          phase_next           = PH_LEN;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_NO_DOLLAR;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          fail      = 1'b1;
          fail_code = ERR_LONE_CR;
        end else if (number_overflow || number > max_arg_length) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_LENGTH;
        end else begin
          in_token_next = 1'b0;
          phase_next    = (number == '0) ? PH_DATA_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        res[0]        = mk(KIND_DATA, b, !in_token, inl, ERR_NONE);
        n_res         = 2'd1;
        in_token_next = 1'b1;
        if (number != '0) begin
          number_next = number - NUM_W'(1);
        end
        if (number <= NUM_W'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (b == CH_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_NO_TRAILER;
        end
      end
      PH_DATA_LF: begin
        if (b != CH_LF) begin
          fail      = 1'b1;
          fail_code = ERR_NO_TRAILER;
        end else begin
          res[0]        = mk(KIND_ARG_END, '0, 1'b0, inl, ERR_NONE);
          n_res         = 2'd1;
          in_token_next = 1'b0;
          if (args_left <= ARGS_W'(1)) begin
            res[1] = mk(KIND_FRAME_END, '0, 1'b0, inl, ERR_NONE);
            n_res  = 2'd2;
            clear  = 1'b1;
          end else begin
            args_left_next = args_left - ARGS_W'(1);
            phase_next     = PH_DOLLAR;
          end
        end
      end
      default: begin
        // Frame start, or starting or continuing an inline line
        if (phase == PH_IDLE && b == CH_STAR) begin
          is_inline_next       = 1'b0;
          args_left_next       = '0;
          number_next          = '0;
          number_overflow_next = 1'b0;
          digit_seen_next      = 1'b0;
          held_cr_next         = 1'b0;
          in_token_next        = 1'b0;
          phase_next           = PH_COUNT;
        end else begin
          is_inline_next = 1'b1;
          phase_next     = PH_INLINE;
          if (hc && b == CH_LF) begin
            if (tk) begin
              res[n_res[0]] = mk(KIND_ARG_END, '0, 1'b0, inl, ERR_NONE);
              n_res         = n_res + 2'd1;
            end
            res[n_res[0]] = mk(KIND_FRAME_END, '0, 1'b0, inl, ERR_NONE);
            n_res         = n_res + 2'd1;
            clear         = 1'b1;
          end else begin
            // A held CR not followed by LF is plain data
            if (hc) begin
              res[n_res[0]] = mk(KIND_DATA, CH_CR, !tk, inl, ERR_NONE);
              n_res         = n_res + 2'd1;
              tk            = 1'b1;
            end
            held_cr_next = 1'b0;
            if (b == CH_CR) begin
              held_cr_next = 1'b1;
            end else if (b == CH_SPACE) begin
              if (tk) begin
                res[n_res[0]] = mk(KIND_ARG_END, '0, 1'b0, inl, ERR_NONE);
                n_res         = n_res + 2'd1;
              end
              tk = 1'b0;
            end else begin
              res[n_res[0]] = mk(KIND_DATA, b, !tk, inl, ERR_NONE);
              n_res         = n_res + 2'd1;
              tk            = 1'b1;
            end
            in_token_next = tk;
          end
        end
      end
    endcase

    if (fail) begin
      res[0] = mk(KIND_ERROR, '0, 1'b0, inl, fail_code);
      n_res  = 2'd1;
      clear  = 1'b1;
    end

    if (clear) begin
      phase_next           = PH_IDLE;
      args_left_next       = '0;
      number_next          = '0;
      number_overflow_next = 1'b0;
      digit_seen_next      = 1'b0;
      held_cr_next         = 1'b0;
      in_token_next        = 1'b0;
    end

    // Mark the final result of this byte
    if (n_res == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n_res == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      args_left       <= '0;
      number          <= '0;
      number_overflow <= 1'b0;
      digit_seen      <= 1'b0;
      held_cr         <= 1'b0;
      in_token        <= 1'b0;
      is_inline       <= 1'b0;
    end else if (in_fire) begin
      phase           <= phase_next;
      args_left       <= args_left_next;
      number          <= number_next;
      number_overflow <= number_overflow_next;
      digit_seen      <= digit_seen_next;
      held_cr         <= held_cr_next;
      in_token        <= in_token_next;
      is_inline       <= is_inline_next;
    end
  end

  // Result queue: push up to two per transfer in, pop one per transfer out
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_res != 2'd0) begin
        fifo[wr_ptr] <= res[0];
      end
      if (n_res == 2'd2) begin
        fifo[wr_ptr + 2'd1] <= res[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + n_res;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (in_fire ? {1'b0, n_res} : 3'd0) - {2'd0, out_fire};
    end
  end

  assign out_ch.valid        = (count != 3'd0);
  assign out_ch.result_kind  = fifo[rd_ptr].result_kind;
  assign out_ch.arg_byte     = fifo[rd_ptr].arg_byte;
  assign out_ch.arg_first    = fifo[rd_ptr].arg_first;
  assign out_ch.frame_inline = fifo[rd_ptr].frame_inline;
  assign out_ch.error_code   = fifo[rd_ptr].error_code;
  assign out_ch.last         = fifo[rd_ptr].last;

  `RRFP_ASSERT_ALWAYS(a_queue_bound, clk, rst, count <= FIFO_DEPTH, "result queue overflow")
  `RRFP_ASSERT_IMPLIES(a_idle_clean, clk, rst, phase == PH_IDLE, (args_left == '0) && !held_cr && !in_token, "frame state left over in idle")
  `RRFP_ASSERT_NEXT(a_star_count, clk, rst, in_fire && phase == PH_IDLE && in_ch.in_byte == CH_STAR, phase == PH_COUNT && number == '0, "star did not start a count line")
  `RRFP_ASSERT_IMPLIES(a_data_len, clk, rst, phase == PH_DATA, number != '0, "data phase with no bytes left")

endmodule
